// ===== rtl/tcpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants of the two-class priority batch queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int MAX_BATCH       = 32;
	localparam int BATCH_W         = $clog2(MAX_BATCH + 1);

	localparam logic       KIND_ADD     = 1'b0;
	localparam logic       KIND_SERVE   = 1'b1;
	localparam logic [7:0] URGENT_PRIO  = 8'd1;

	typedef struct packed {
		logic [15:0] task_id;
		logic [7:0]  prio;
		logic [15:0] hour;
	} entry_t;

	typedef enum logic [1:0] {
		ST_SERVED  = 2'd0,
		ST_ADDED   = 2'd1,
		ST_DROPPED = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FIRST,
		S_NEXT,
		S_LAST
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/tcpq_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_mem
// Task store of one queue: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcpq_mem #(
	parameter int DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire tcpq_pkg::entry_t wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output tcpq_pkg::entry_t      rdata
);

	tcpq_pkg::entry_t mem [DEPTH];
	tcpq_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold the last read word until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/two_class_priority_batch_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Add, drop and empty-serve requests: result goes to the output register at accept;
//   back-to-back adds run at one request per cycle while the sink is ready.
// Serve: entries pass the store read register and pend_q to the output; one result per cycle
//   while hours match and the sink is ready; the next request waits for the last result.
// Reset clears pointers, counts and control; the task stores are not cleared and no entry
//   is read before it is written.
// ----------------------------------------------------------------------------
// two_class_priority_batch_queue
// Urgent and regular task FIFOs in synchronous stores with strict-priority batch serving.
// ----------------------------------------------------------------------------
module two_class_priority_batch_queue #(
	parameter int QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [15:0] task_id,
	input  wire logic [7:0]  priority_req,
	input  wire logic [15:0] hour,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [15:0]      task_id_res,
	output logic [7:0]       priority_res,
	output logic [15:0]      hour_res,
	output logic             from_urgent,
	output logic             last
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int BW = tcpq_pkg::BATCH_W;

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
		return (i == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(i + 1'b1);
	endfunction

	tcpq_pkg::state_t state_q, state_d;

	logic [AW-1:0] uhead_q, utail_q, rhead_q, rtail_q;
	logic [CW-1:0] ucnt_q, rcnt_q;
	logic          sel_urg_q;
	logic [BW-1:0] n_q;
	tcpq_pkg::entry_t pend_q;

	logic             out_valid_q;
	tcpq_pkg::status_t status_q;
	tcpq_pkg::entry_t out_entry_q;
	logic             from_urgent_q;
	logic             last_q;

	logic             u_we, u_re, r_we, r_re;
	logic [AW-1:0]    u_raddr, r_raddr;
	tcpq_pkg::entry_t u_rdata, r_rdata, wr_entry, rd_data;

	logic          out_free, acc, in_urg, u_full, r_full, add_ok, serve_go, serve_urg;
	logic          same, pop_first, pop_next, pop, more;
	logic [AW-1:0] cur_head, head_nx;
	logic [CW-1:0] cur_cnt, cnt_after;
	logic [BW-1:0] n_after;
	logic          load_in, load_pend, load_pend_last;

	assign out_free  = !out_valid_q || out_ready;
	assign acc       = in_valid && in_ready;
	assign in_urg    = (priority_req == tcpq_pkg::URGENT_PRIO);
	assign u_full    = (ucnt_q == CW'(QUEUE_DEPTH));
	assign r_full    = (rcnt_q == CW'(QUEUE_DEPTH));
	assign serve_urg = (ucnt_q != '0);
	assign add_ok    = acc && (kind == tcpq_pkg::KIND_ADD) && !(in_urg ? u_full : r_full);
	assign serve_go  = acc && (kind == tcpq_pkg::KIND_SERVE) && (serve_urg || rcnt_q != '0);

	assign wr_entry  = '{task_id: task_id, prio: priority_req, hour: hour};

	assign rd_data   = sel_urg_q ? u_rdata : r_rdata;
	assign cur_head  = sel_urg_q ? uhead_q : rhead_q;
	assign cur_cnt   = sel_urg_q ? ucnt_q : rcnt_q;
	assign head_nx   = next_idx(cur_head);
	assign cnt_after = CW'(cur_cnt - 1'b1);

	// every entry held in pend_q shares the batch hour
	assign same      = (rd_data.hour == pend_q.hour);
	assign pop_first = (state_q == tcpq_pkg::S_FIRST);
	assign pop_next  = (state_q == tcpq_pkg::S_NEXT) && same && out_free;
	assign pop       = pop_first || pop_next;
	assign n_after   = pop_first ? BW'(1) : BW'(n_q + 1'b1);
	assign more      = pop && (cnt_after != '0) && (n_after < BW'(tcpq_pkg::MAX_BATCH));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcpq_pkg::S_IDLE: begin
				if (serve_go) state_d = tcpq_pkg::S_FIRST;
			end
			tcpq_pkg::S_FIRST: begin
				state_d = more ? tcpq_pkg::S_NEXT : tcpq_pkg::S_LAST;
			end
			tcpq_pkg::S_NEXT: begin
				if (!same) state_d = tcpq_pkg::S_LAST;
				else if (out_free) state_d = more ? tcpq_pkg::S_NEXT : tcpq_pkg::S_LAST;
			end
			tcpq_pkg::S_LAST: begin
				if (out_free) state_d = tcpq_pkg::S_IDLE;
			end
			default: state_d = tcpq_pkg::S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready       = 1'b0;
		load_pend_last = 1'b0;
		case (state_q)
			tcpq_pkg::S_IDLE: in_ready       = out_free;
			tcpq_pkg::S_LAST: load_pend_last = out_free;
			default: begin
				in_ready       = 1'b0;
				load_pend_last = 1'b0;
			end
		endcase
	end

	assign load_in   = acc && !serve_go;
	assign load_pend = pop_next;

	// store ports: stores are touched by one request at a time, so no forwarding is needed
	assign u_we    = add_ok && in_urg;
	assign r_we    = add_ok && !in_urg;
	assign u_re    = (serve_go && serve_urg) || (more && sel_urg_q);
	assign r_re    = (serve_go && !serve_urg) || (more && !sel_urg_q);
	assign u_raddr = serve_go ? uhead_q : head_nx;
	assign r_raddr = serve_go ? rhead_q : head_nx;

	tcpq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_urgent_mem (
		.clk   (clk),
		.we    (u_we),
		.waddr (utail_q),
		.wdata (wr_entry),
		.re    (u_re),
		.raddr (u_raddr),
		.rdata (u_rdata)
	);

	tcpq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_regular_mem (
		.clk   (clk),
		.we    (r_we),
		.waddr (rtail_q),
		.wdata (wr_entry),
		.re    (r_re),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tcpq_pkg::S_IDLE;
			uhead_q   <= '0;
			utail_q   <= '0;
			ucnt_q    <= '0;
			rhead_q   <= '0;
			rtail_q   <= '0;
			rcnt_q    <= '0;
			sel_urg_q <= 1'b0;
			n_q       <= '0;
		end else begin
			state_q <= state_d;
			if (serve_go) sel_urg_q <= serve_urg;
			if (pop) n_q <= n_after;
			if (u_we) begin
				utail_q <= next_idx(utail_q);
				ucnt_q  <= CW'(ucnt_q + 1'b1);
			end
			if (r_we) begin
				rtail_q <= next_idx(rtail_q);
				rcnt_q  <= CW'(rcnt_q + 1'b1);
			end
			// advance the head of the queue being served
			if (pop && sel_urg_q) begin
				uhead_q <= head_nx;
				ucnt_q  <= cnt_after;
			end
			if (pop && !sel_urg_q) begin
				rhead_q <= head_nx;
				rcnt_q  <= cnt_after;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) pend_q <= rd_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_in || load_pend || load_pend_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_in) begin
			last_q <= 1'b1;
			if (kind == tcpq_pkg::KIND_SERVE) begin
				status_q      <= tcpq_pkg::ST_EMPTY;
				out_entry_q   <= '0;
				from_urgent_q <= 1'b0;
			end else begin
				status_q      <= (in_urg ? u_full : r_full) ? tcpq_pkg::ST_DROPPED
				                                            : tcpq_pkg::ST_ADDED;
				out_entry_q   <= wr_entry;
				from_urgent_q <= in_urg;
			end
		end else if (load_pend || load_pend_last) begin
			status_q      <= tcpq_pkg::ST_SERVED;
			out_entry_q   <= pend_q;
			from_urgent_q <= sel_urg_q;
			last_q        <= load_pend_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign task_id_res  = out_entry_q.task_id;
	assign priority_res = out_entry_q.prio;
	assign hour_res     = out_entry_q.hour;
	assign from_urgent  = from_urgent_q;
	assign last         = last_q;

	a_urgent_read_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		u_re |-> (ucnt_q != '0))
		else $error("urgent store read while queue empty");

	a_regular_read_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		r_re |-> (rcnt_q != '0))
		else $error("regular store read while queue empty");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(ucnt_q == '0) |-> (uhead_q == utail_q))
		else $error("urgent pointers disagree with empty count");

	a_batch_mid: assert property (@(posedge clk) disable iff (!arst_n)
		pop_next |=> (out_valid_q && !last_q && status_q == tcpq_pkg::ST_SERVED))
		else $error("batch result not marked as continuing");

	a_batch_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcpq_pkg::S_LAST && out_free) |=>
		(state_q == tcpq_pkg::S_IDLE && out_valid_q && last_q))
		else $error("batch did not close with a last result");

endmodule
`default_nettype wire

// ===== bench/tb_two_class_priority_batch_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_class_priority_batch_queue
// Self-checking bench for the two-class priority batch queue. Add and serve
// requests go through a valid/ready sender with random gaps. A scoreboard
// keeps its own urgent and regular task lists and predicts every result:
// adds, drops at a full queue, batch serves by matching hour, and empty serves.
// The result sink stalls at random and once holds off long enough to back up
// the input side.
// ----------------------------------------------------------------------------
module tb_two_class_priority_batch_queue;

	localparam int DEPTH     = tcpq_pkg::QUEUE_DEPTH_DEF;
	localparam int RAND_REQS = 490;
	localparam int TAIL_CYC  = 20;

	typedef struct {
		tcpq_pkg::status_t status;
		logic [15:0]       task_id;
		logic [7:0]        prio;
		logic [15:0]       hour;
		logic              from_urgent;
		logic              last;
	} sched_result_t;

	class batch_scoreboard;
		tcpq_pkg::entry_t urgent_fifo[$];
		tcpq_pkg::entry_t regular_fifo[$];
		sched_result_t    pending_results[$];
		int               mismatches;
		int               adds, drops, serves, empties, longest_batch;

		task report(string msg);
			mismatches++;
			$display("[%0t] MISMATCH: %s", $time, msg);
		endtask

		function int pending();
			return pending_results.size();
		endfunction

		// predict the results of one accepted request
		function void note_request(logic k, logic [15:0] id, logic [7:0] prio,
				logic [15:0] hr);
			tcpq_pkg::entry_t e;
			sched_result_t    r;
			logic [15:0]      batch_hour;
			int               n;
			e.task_id     = id;
			e.prio        = prio;
			e.hour        = hr;
			r.status      = tcpq_pkg::ST_ADDED;
			r.task_id     = id;
			r.prio        = prio;
			r.hour        = hr;
			r.from_urgent = (prio == tcpq_pkg::URGENT_PRIO);
			r.last        = 1'b1;
			if (k == tcpq_pkg::KIND_ADD) begin
				if ((r.from_urgent && urgent_fifo.size() >= DEPTH) ||
				    (!r.from_urgent && regular_fifo.size() >= DEPTH)) begin
					r.status = tcpq_pkg::ST_DROPPED;
					drops++;
				end else if (r.from_urgent) begin
					urgent_fifo.push_back(e);
					adds++;
				end else begin
					regular_fifo.push_back(e);
					adds++;
				end
				pending_results.push_back(r);
			end else if (urgent_fifo.size() == 0 && regular_fifo.size() == 0) begin
				r = '{tcpq_pkg::ST_EMPTY, 16'h0000, 8'h00, 16'h0000, 1'b0, 1'b1};
				empties++;
				pending_results.push_back(r);
			end else begin
				r.from_urgent = (urgent_fifo.size() != 0);
				batch_hour = r.from_urgent ? urgent_fifo[0].hour : regular_fifo[0].hour;
				n = 0;
				// pop heads while the hour matches the first one
				while (n < tcpq_pkg::MAX_BATCH) begin
					if (r.from_urgent) begin
						if (urgent_fifo.size() == 0 || urgent_fifo[0].hour != batch_hour)
							break;
						e = urgent_fifo.pop_front();
					end else begin
						if (regular_fifo.size() == 0 || regular_fifo[0].hour != batch_hour)
							break;
						e = regular_fifo.pop_front();
					end
					r.status  = tcpq_pkg::ST_SERVED;
					r.task_id = e.task_id;
					r.prio    = e.prio;
					r.hour    = e.hour;
					r.last    = 1'b0;
					pending_results.push_back(r);
					n++;
				end
				pending_results[pending_results.size() - 1].last = 1'b1;
				serves++;
				if (n > longest_batch)
					longest_batch = n;
			end
		endfunction

		task check_result(logic [1:0] st, logic [15:0] id, logic [7:0] prio,
				logic [15:0] hr, logic urg, logic lst);
			sched_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result with nothing pending: status=%0d id=%h", st, id));
			end else begin
				want = pending_results.pop_front();
				if (st !== want.status || id !== want.task_id || prio !== want.prio ||
				    hr !== want.hour || urg !== want.from_urgent || lst !== want.last)
					report({$sformatf("got st=%0d id=%h pr=%h hr=%h urg=%b last=%b",
						st, id, prio, hr, urg, lst),
						$sformatf(", want st=%0d id=%h pr=%h hr=%h urg=%b last=%b",
						want.status, want.task_id, want.prio, want.hour,
						want.from_urgent, want.last)});
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        req_kind;
	logic [15:0] req_task_id;
	logic [7:0]  req_prio;
	logic [15:0] req_hour;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  res_status;
	logic [15:0] res_task_id;
	logic [7:0]  res_prio;
	logic [15:0] res_hour;
	logic        res_from_urgent;
	logic        res_last;

	batch_scoreboard sb;
	bit              tx_gaps;
	bit              rand_phase;
	bit              rx_hold;

	always #5 clk = ~clk;

	two_class_priority_batch_queue #(
		.QUEUE_DEPTH(DEPTH)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (req_kind),
		.task_id     (req_task_id),
		.priority_req(req_prio),
		.hour        (req_hour),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (res_status),
		.task_id_res (res_task_id),
		.priority_res(res_prio),
		.hour_res    (res_hour),
		.from_urgent (res_from_urgent),
		.last        (res_last)
	);

	function logic [7:0] regular_prio();
		logic [7:0] p;
		p = 8'($urandom);
		if (p == tcpq_pkg::URGENT_PRIO)
			p = 8'h00;
		return p;
	endfunction

	// offer one request after a random gap and hold it until accepted
	task send_request(logic k, logic [15:0] id, logic [7:0] prio, logic [15:0] hr);
		int unsigned gap;
		gap = tx_gaps ? $urandom_range(0, 12) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		req_kind    <= k;
		req_task_id <= id;
		req_prio    <= prio;
		req_hour    <= hr;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		sb.note_request(k, id, prio, hr);
	endtask

	task idle_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// hold the sender until every predicted result has come back
	task wait_drained();
		idle_input();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : request_source
		int unsigned sent, mode, len, nserve, i, bursts;
		logic [15:0] base;
		logic        urg;
		sb          = new();
		in_valid    = 1'b0;
		req_kind    = tcpq_pkg::KIND_ADD;
		req_task_id = 16'h0000;
		req_prio    = 8'h00;
		req_hour    = 16'h0000;
		out_ready   = 1'b0;
		rx_hold     = 1'b0;
		rand_phase  = 1'b0;
		tx_gaps     = 1'b0;
		arst_n      = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty serve, both classes, field extremes, hour batching
		send_request(tcpq_pkg::KIND_SERVE, 16'h0000, 8'h00, 16'h0000);
		send_request(tcpq_pkg::KIND_ADD, 16'h0000, tcpq_pkg::URGENT_PRIO, 16'h0000);
		send_request(tcpq_pkg::KIND_ADD, 16'hFFFF, 8'h00, 16'hFFFF);
		send_request(tcpq_pkg::KIND_ADD, 16'h1234, 8'hFF, 16'hFFFF);
		send_request(tcpq_pkg::KIND_ADD, 16'h5A5A, 8'h02, 16'h0007);
		send_request(tcpq_pkg::KIND_ADD, 16'hAAAA, tcpq_pkg::URGENT_PRIO, 16'h0000);
		send_request(tcpq_pkg::KIND_ADD, 16'h5555, tcpq_pkg::URGENT_PRIO, 16'h0001);
		send_request(tcpq_pkg::KIND_ADD, 16'h0F0F, 8'h80, 16'h0007);
		send_request(tcpq_pkg::KIND_SERVE, 16'h0000, 8'h00, 16'h0000);
		send_request(tcpq_pkg::KIND_SERVE, 16'h0000, 8'h00, 16'h0000);
		send_request(tcpq_pkg::KIND_SERVE, 16'h0000, 8'h00, 16'h0000);
		send_request(tcpq_pkg::KIND_SERVE, 16'h0000, 8'h00, 16'h0000);
		// serve fields are don't-care; drive them hot
		send_request(tcpq_pkg::KIND_SERVE, 16'hFFFF, tcpq_pkg::URGENT_PRIO, 16'hFFFF);
		send_request(tcpq_pkg::KIND_SERVE, 16'hFFFF, 8'hFF, 16'hFFFF);
		wait_drained();

		rand_phase = 1'b1;
		sent   = 0;
		bursts = 0;
		while (sent < RAND_REQS) begin
			tx_gaps = ($urandom_range(0, 3) != 0);
			mode    = $urandom_range(0, 9);
			base    = 16'($urandom);
			if (bursts < 2 || mode < 2) begin
				// fill one class to near or past full at a single hour, then serve it out
				urg = bursts[0];
				bursts++;
				len    = $urandom_range(DEPTH - 2, DEPTH + 4);
				nserve = $urandom_range(1, 3);
				for (i = 0; i < len; i++)
					send_request(tcpq_pkg::KIND_ADD, 16'($urandom),
						urg ? tcpq_pkg::URGENT_PRIO : regular_prio(), base);
				for (i = 0; i < nserve; i++)
					send_request(tcpq_pkg::KIND_SERVE, 16'($urandom), 8'($urandom),
						16'($urandom));
				len += nserve;
			end else if (mode < 8) begin
				// mixed traffic over two neighboring hours so batches form
				len = $urandom_range(4, 16);
				for (i = 0; i < len; i++) begin
					if ($urandom_range(0, 9) < 6)
						send_request(tcpq_pkg::KIND_ADD, 16'($urandom),
							($urandom_range(0, 2) == 0) ? tcpq_pkg::URGENT_PRIO
							                            : regular_prio(),
							base + 16'($urandom_range(0, 1)));
					else
						send_request(tcpq_pkg::KIND_SERVE, 16'($urandom), 8'($urandom),
							16'($urandom));
				end
			end else begin
				len = $urandom_range(2, 8);
				for (i = 0; i < len; i++)
					send_request(1'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
			end
			sent += len;
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (TAIL_CYC) @(posedge clk);
		$display("Covered %0d tasks queued, %0d dropped at full, %0d empty serves",
			sb.adds, sb.drops, sb.empties);
		$display("Served %0d batches, longest batch %0d tasks, %0d mismatches",
			sb.serves, sb.longest_batch, sb.mismatches);
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : result_sink
		int unsigned gap, taken;
		bit          calm;
		taken = 0;
		calm  = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			// switch between stalling and streaming every so often
			if (taken % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			gap = calm ? 0 : $urandom_range(0, 12);
			repeat (gap) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			do begin
				@(negedge clk);
				out_ready <= !rx_hold;
				@(posedge clk);
			end while (!(out_valid === 1'b1 && out_ready === 1'b1));
			sb.check_result(res_status, res_task_id, res_prio, res_hour,
				res_from_urgent, res_last);
			taken++;
		end
	end

	// block the result side long enough for the input side to back up
	initial begin : long_hold
		wait (rand_phase);
		repeat (40) @(posedge clk);
		rx_hold = 1'b1;
		repeat (400) @(posedge clk);
		rx_hold = 1'b0;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Run timed out");
		$display("TB_ERROR");
		$finish;
	end

endmodule
